// File: rtl/rcam_pkg.sv
package rcam_pkg;

  // Fixed field widths.
  localparam int unsigned PIXEL_BITS    = 32;
  localparam int unsigned CFG_DATA_BITS = 14;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned RADIUS_BITS   = 8;

  // Offset from the arc center, its square and the sum of two squares.
  localparam int unsigned A_BITS   = RADIUS_BITS + 1;
  localparam int unsigned SQ_BITS  = 2 * A_BITS;
  localparam int unsigned SUM_BITS = SQ_BITS + 1;

  localparam int unsigned ALPHA_BITS = 8;
  localparam int unsigned COLOR_BITS = PIXEL_BITS - ALPHA_BITS;

  typedef logic [PIXEL_BITS-1:0]    pixel_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [RADIUS_BITS-1:0]   radius_t;
  typedef logic [A_BITS-1:0]        offset_t;
  typedef logic [SQ_BITS-1:0]       square_t;
  typedef logic [SUM_BITS-1:0]      dist_sum_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CORNER_RADIUS = 2'd2
  } cfg_reg_e;

  // Data that rides alongside the distance computation.
  typedef struct packed {
    logic   pass;
    pixel_t pixel;
  } side_t;

endpackage

// File: rtl/rcam_front.sv
module rcam_front #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COORD_BITS-1:0]     column_i,
  input  logic [COORD_BITS-1:0]     row_index_i,
  input  rcam_pkg::pixel_t          pixel_in_i,
  input  logic [COORD_BITS-1:0]     width_i,
  input  logic [COORD_BITS-1:0]     height_i,
  input  rcam_pkg::radius_t         radius_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rcam_pkg::dist_sum_t       out_sum_o,
  output rcam_pkg::side_t           out_side_o
);
  import rcam_pkg::*;

  // Common width for comparing coordinates against twice the radius.
  localparam int unsigned CW = (COORD_BITS > A_BITS) ? COORD_BITS : A_BITS;

  logic [CW-1:0] col_ext, row_ext, w_ext, h_ext, r_ext, r2_ext;
  logic [CW-1:0] col_mirror, row_mirror;
  logic          carve_on, col_in, row_in;
  radius_t       x_loc, y_loc;
  offset_t       a_val, b_val, r2m1;

  // Stage registers.
  logic      s1_valid_q, s2_valid_q, s3_valid_q;
  logic      s1_ready, s2_ready, s3_ready;
  side_t     s1_side_q, s2_side_q, s3_side_q;
  offset_t   s1_a_q, s1_b_q, s1_r2m1_q;
  square_t   s2_sqa_q, s2_sqb_q, s2_lim_q;
  dist_sum_t s3_sum_q;
  dist_sum_t sum_d;

  assign col_ext = CW'(column_i);
  assign row_ext = CW'(row_index_i);
  assign w_ext   = CW'(width_i);
  assign h_ext   = CW'(height_i);
  assign r_ext   = CW'(radius_i);
  assign r2_ext  = CW'({radius_i, 1'b0});

  // Carving needs a nonzero radius and room for two corners each way.
  assign carve_on = (radius_i != '0) && (w_ext >= r2_ext) && (h_ext >= r2_ext);

  // Mirror the position into the top-left corner square.
  assign col_mirror = w_ext - CW'(1) - col_ext;
  assign row_mirror = h_ext - CW'(1) - row_ext;

  always_comb begin
    col_in = 1'b0;
    x_loc  = '0;
    if (col_ext < w_ext) begin
      if (col_ext < r_ext) begin
        col_in = 1'b1;
        x_loc  = col_ext[RADIUS_BITS-1:0];
      end else if (col_ext >= w_ext - r_ext) begin
        col_in = 1'b1;
        x_loc  = col_mirror[RADIUS_BITS-1:0];
      end
    end
  end

  always_comb begin
    row_in = 1'b0;
    y_loc  = '0;
    if (row_ext < h_ext) begin
      if (row_ext < r_ext) begin
        row_in = 1'b1;
        y_loc  = row_ext[RADIUS_BITS-1:0];
      end else if (row_ext >= h_ext - r_ext) begin
        row_in = 1'b1;
        y_loc  = row_mirror[RADIUS_BITS-1:0];
      end
    end
  end

  // Doubled offsets from the arc center: 2r-1-2x and 2r-1-2y.
  assign r2m1  = {radius_i, 1'b0} - A_BITS'(1);
  assign a_val = r2m1 - {x_loc, 1'b0};
  assign b_val = r2m1 - {y_loc, 1'b0};

  // Each stage loads when empty or when its successor takes its word.
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Control for the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 1: corner mapping.
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_side_q.pass  <= !(carve_on && col_in && row_in);
      s1_side_q.pixel <= pixel_in_i;
      s1_a_q          <= a_val;
      s1_b_q          <= b_val;
      s1_r2m1_q       <= r2m1;
    end
  end

  // Stage 2: squares and the pass limit.
  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_side_q <= s1_side_q;
      s2_sqa_q  <= SQ_BITS'(s1_a_q * s1_a_q);
      s2_sqb_q  <= SQ_BITS'(s1_b_q * s1_b_q);
      s2_lim_q  <= SQ_BITS'(s1_r2m1_q * s1_r2m1_q);
    end
  end

  // Stage 3: sum of squares and the exact pass test.
  assign sum_d = SUM_BITS'(s2_sqa_q) + SUM_BITS'(s2_sqb_q);

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_side_q.pixel <= s2_side_q.pixel;
      s3_side_q.pass  <= s2_side_q.pass || (sum_d <= SUM_BITS'(s2_lim_q));
      s3_sum_q        <= sum_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_sum_o   = s3_sum_q;
  assign out_side_o  = s3_side_q;

endmodule

// File: rtl/rcam_sqrt_cell.sv
module rcam_sqrt_cell #(
  parameter int unsigned ROOT_BITS = 14,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ROOT_BITS+1:0]   in_rem_i,
  input  logic [ROOT_BITS-1:0]   in_root_i,
  input  rcam_pkg::dist_sum_t    in_sum_i,
  input  rcam_pkg::side_t        in_side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ROOT_BITS+1:0]   out_rem_o,
  output logic [ROOT_BITS-1:0]   out_root_o,
  output rcam_pkg::dist_sum_t    out_sum_o,
  output rcam_pkg::side_t        out_side_o
);
  import rcam_pkg::*;

  localparam int unsigned REM_W = ROOT_BITS + 2;
  localparam int unsigned RAD_W = 2 * ROOT_BITS;
  localparam int unsigned LO    = 2 * (ROOT_BITS - 1 - CELL_IDX);

  logic [RAD_W-1:0]     radicand;
  logic [REM_W-1:0]     rem_sh, trial;
  logic                 take;
  logic                 valid_q;
  logic [REM_W-1:0]     rem_q;
  logic [ROOT_BITS-1:0] root_q;
  dist_sum_t            sum_q;
  side_t                side_q;

  // This cell brings down one pair of radicand bits, scaled by the fraction bits.
  assign radicand = RAD_W'(in_sum_i) << (2 * FRAC_BITS);
  assign rem_sh   = {in_rem_i[REM_W-3:0], radicand[LO+1:LO]};
  assign trial    = {in_root_i, 2'b01};
  assign take     = (rem_sh >= trial);

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // One restoring step: subtract the trial value when it fits.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {in_root_i[ROOT_BITS-2:0], take};
      sum_q  <= in_sum_i;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_root_o  = root_q;
  assign out_sum_o   = sum_q;
  assign out_side_o  = side_q;

endmodule

// File: rtl/rounded_corner_alpha_mask_top.sv
// Rounded corner alpha mask.
// Input channel: in_valid_i / in_stall_o carry one word per pixel: column_i,
// row_index_i and pixel_in_i (ARGB, alpha in the top byte). Output channel:
// out_valid_o / out_stall_i carry pixel_out_o, one word per input word, in
// order. A word moves at a clock edge with valid high and stall low.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) for
// image width, image height and corner radius; write it only while idle.
// A word passes 3 + ROOT_BITS + 1 register stages, where ROOT_BITS is
// (20 + 2*DIST_FRAC_BITS)/2, the number of square-root cells. That is 22 stages
// at DIST_FRAC_BITS = 8. Three front stages map the corner and form the
// squares and their sum, each cell of the square root chain produces one root
// bit, and a last stage forms alpha and holds the result. One pixel is taken
// every cycle while in_stall_o is low.
// When the receiver stalls, the output register holds its word and stages
// upstream keep filling until the chain is full; only then does in_stall_o
// rise. Reset empties the pipeline and clears the configuration registers to
// zero, which turns carving off.
module rounded_corner_alpha_mask_top #(
  parameter int unsigned COORD_BITS     = 14,
  parameter int unsigned DIST_FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  rcam_pkg::cfg_idx_t      cfg_idx_i,
  input  rcam_pkg::cfg_data_t     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   column_i,
  input  logic [COORD_BITS-1:0]   row_index_i,
  input  rcam_pkg::pixel_t        pixel_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output rcam_pkg::pixel_t        pixel_out_o
);
  import rcam_pkg::*;

  localparam int unsigned ROOT_BITS = (SUM_BITS + 2 * DIST_FRAC_BITS + 1) / 2;
  localparam int unsigned REM_W     = ROOT_BITS + 2;
  localparam int unsigned T_BITS    = A_BITS + DIST_FRAC_BITS;
  localparam int unsigned P_BITS    = T_BITS + 9;
  localparam int unsigned AF_BITS   = P_BITS - DIST_FRAC_BITS - 1;

  // Configuration registers.
  cfg_data_t width_q, height_q;
  radius_t   radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
        CFG_CORNER_RADIUS: radius_q <= cfg_data_i[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: corner mapping, squares and pass test.
  logic                 front_ready;
  logic                 chain_valid [0:ROOT_BITS];
  logic                 chain_ready [0:ROOT_BITS];
  logic [REM_W-1:0]     chain_rem   [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] chain_root  [0:ROOT_BITS];
  dist_sum_t            chain_sum   [0:ROOT_BITS];
  side_t                chain_side  [0:ROOT_BITS];

  rcam_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .column_i    (column_i),
    .row_index_i (row_index_i),
    .pixel_in_i  (pixel_in_i),
    .width_i     (COORD_BITS'(width_q)),
    .height_i    (COORD_BITS'(height_q)),
    .radius_i    (radius_q),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_sum_o   (chain_sum[0]),
    .out_side_o  (chain_side[0])
  );

  assign in_stall_o    = !front_ready;
  assign chain_rem[0]  = '0;
  assign chain_root[0] = '0;

  // Square root chain, one result bit per cell.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
    rcam_sqrt_cell #(
      .ROOT_BITS (ROOT_BITS),
      .FRAC_BITS (DIST_FRAC_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_rem_i    (chain_rem[k]),
      .in_root_i   (chain_root[k]),
      .in_sum_i    (chain_sum[k]),
      .in_side_i   (chain_side[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_rem_o   (chain_rem[k+1]),
      .out_root_o  (chain_root[k+1]),
      .out_sum_o   (chain_sum[k+1]),
      .out_side_o  (chain_side[k+1])
    );
  end

  // Alpha from the distance: round(255 * (T - S) / 2^(F+1)), capped at 255, zero when S >= T.
  logic [ROOT_BITS-1:0] dist_s, thresh_t;
  logic [T_BITS-1:0]    diff;
  logic [P_BITS-1:0]    scaled;
  logic [AF_BITS-1:0]   alpha_full;
  logic [ALPHA_BITS-1:0] alpha;
  pixel_t               pixel_d, pixel_q;
  logic                 out_valid_q;
  side_t                last_side;

  assign dist_s    = chain_root[ROOT_BITS];
  assign last_side = chain_side[ROOT_BITS];
  assign thresh_t  = ROOT_BITS'({radius_q, 1'b1}) << DIST_FRAC_BITS;
  assign diff      = T_BITS'(thresh_t - dist_s);
  assign scaled    = (P_BITS'(diff) << 8) - P_BITS'(diff)
                     + (P_BITS'(1) << DIST_FRAC_BITS);
  assign alpha_full = scaled[P_BITS-1:DIST_FRAC_BITS+1];

  always_comb begin
    if (dist_s >= thresh_t) begin
      alpha = '0;
    end else if (alpha_full > AF_BITS'(255)) begin
      alpha = '1;
    end else begin
      alpha = alpha_full[ALPHA_BITS-1:0];
    end
  end

  always_comb begin
    if (last_side.pass) begin
      pixel_d = last_side.pixel;
    end else if (alpha == '0) begin
      pixel_d = '0;
    end else begin
      pixel_d = {alpha, last_side.pixel[COLOR_BITS-1:0]};
    end
  end

  // Output register.
  assign chain_ready[ROOT_BITS] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[ROOT_BITS]) begin
      out_valid_q <= chain_valid[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[ROOT_BITS]) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

endmodule
